// ===== rtl/rfc_pkg.sv =====
package rfc_pkg;

	localparam int DATA_W    = 8;
	localparam int RAIL_W    = 5;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_RAIL_COUNT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODE = CFG_IDX_W'(1);

	localparam logic [RAIL_W-1:0] RAIL_COUNT_RESET = RAIL_W'(3);

	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_PERM,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic store_wr;
		logic perm_start;
		logic walk;
		logic emit_rd;
		logic out_take;
		logic run_clear;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic emit_left;
		logic out_valid;
		logic out_final;
	} dp_status_t;

endpackage

// ===== rtl/rfc_in_if.sv =====
interface rfc_in_if;
	import rfc_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

// ===== rtl/rfc_out_if.sv =====
interface rfc_out_if;
	import rfc_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] result_byte;
	logic              final_result;
	logic              overflow_flag;

	modport source (output valid, output result_byte, output final_result,
		output overflow_flag, input ready);
	modport sink   (input valid, input result_byte, input final_result,
		input overflow_flag, output ready);
endinterface

// ===== rtl/rfc_cfg_if.sv =====
interface rfc_cfg_if;
	import rfc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [RAIL_W-1:0]    wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== rtl/rfc_ctl.sv =====
module rfc_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	input  logic                msg_eom,
	input  logic                out_ready,
	input  rfc_pkg::dp_status_t status,
	output logic                msg_ready,
	output rfc_pkg::dp_cmd_t    cmd
);
	import rfc_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		msg_ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				msg_ready = 1'b1;
				if (msg_valid) begin
					cmd.store_wr = 1'b1;
					if (msg_eom) begin
						cmd.perm_start = 1'b1;
						state_nxt      = ST_PERM;
					end
				end
			end
			ST_PERM: begin
				// last result write lands on the edge that leaves this state
				if (status.walk_done) begin
					state_nxt = ST_EMIT;
				end else begin
					cmd.walk = 1'b1;
				end
			end
			ST_EMIT: begin
				cmd.out_take = status.out_valid && out_ready;
				cmd.emit_rd  = status.emit_left && (!status.out_valid || out_ready);
				if (cmd.out_take && status.out_final) begin
					cmd.run_clear = 1'b1;
					state_nxt     = ST_LOAD;
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && msg_valid && msg_eom) |=> (state_q == ST_PERM))
		else $error("message end did not start the permute pass");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PERM) |-> !status.out_valid)
		else $error("output valid while permuting");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_rd |-> (state_q == ST_EMIT))
		else $error("result read outside emit");
endmodule

// ===== rtl/rfc_dp.sv =====
module rfc_dp #(
	parameter int MAX_LEN   = 64,
	parameter int MAX_RAILS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rfc_pkg::dp_cmd_t                    cmd,
	input  logic [rfc_pkg::DATA_W-1:0]          data_byte,
	input  logic                                cfg_wr,
	input  logic [rfc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rfc_pkg::RAIL_W-1:0]          cfg_data,
	output rfc_pkg::dp_status_t                 status,
	output logic [rfc_pkg::DATA_W-1:0]          result_byte,
	output logic                                final_result,
	output logic                                overflow_flag
);
	import rfc_pkg::*;

	localparam int AW    = $clog2(MAX_LEN);
	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int ROW_W = $clog2(MAX_RAILS + 1);
	localparam int STP_W = ROW_W + 1;
	localparam int POS_W = $clog2(MAX_LEN + 2 * MAX_RAILS + 1);

	logic [RAIL_W-1:0] rail_q;
	logic              mode_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;

	logic [ROW_W-1:0]  rails_q;
	logic [ROW_W-1:0]  row_q;
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  k_q;
	logic              phase_q;
	logic              wv_s1;
	logic [AW-1:0]     wa_s1;
	logic [DATA_W-1:0] st_rd_s1;

	logic [CNT_W-1:0]  em_cnt_q;
	logic              out_valid_q;
	logic              final_q;
	logic [DATA_W-1:0] out_q;

	logic [DATA_W-1:0] store_mem [MAX_LEN];
	logic [DATA_W-1:0] res_mem   [MAX_LEN];

	logic [ROW_W-1:0]  rails_eff;
	logic [STP_W-1:0]  span;
	logic [STP_W-1:0]  d_down;
	logic [STP_W-1:0]  d_up;
	logic [STP_W-1:0]  step;
	logic              pair;
	logic              store_has_room;
	logic [AW-1:0]     walk_rd_addr;
	logic [AW-1:0]     walk_wr_addr;

	// rail count 0 acts as 1, large counts saturate
	always_comb begin
		if (rail_q == '0) begin
			rails_eff = ROW_W'(1);
		end else if (int'(rail_q) > MAX_RAILS) begin
			rails_eff = ROW_W'(MAX_RAILS);
		end else begin
			rails_eff = ROW_W'(rail_q);
		end
	end

	// positions on one rail alternate between two gaps that sum to the period
	assign span   = {rails_q - 1'b1, 1'b0};
	assign d_up   = {row_q, 1'b0};
	assign d_down = span - d_up;

	always_comb begin
		if (span == '0) begin
			step = STP_W'(1);
		end else if (!phase_q) begin
			step = (d_down != '0) ? d_down : d_up;
		end else begin
			step = (d_up != '0) ? d_up : d_down;
		end
	end

	assign pair           = (POS_W'(pos_q) < POS_W'(count_q));
	assign store_has_room = (count_q < CNT_W'(MAX_LEN));
	assign walk_rd_addr   = (mode_q == MODE_DECRYPT) ? k_q[AW-1:0] : pos_q[AW-1:0];
	assign walk_wr_addr   = (mode_q == MODE_DECRYPT) ? pos_q[AW-1:0] : k_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rail_q <= RAIL_COUNT_RESET;
			mode_q <= MODE_ENCRYPT;
		end else if (cfg_wr) begin
			if (cfg_index == REG_RAIL_COUNT) begin
				rail_q <= cfg_data;
			end else if (cfg_index == REG_CIPHER_MODE) begin
				mode_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			rails_q     <= ROW_W'(1);
			row_q       <= '0;
			pos_q       <= '0;
			k_q         <= '0;
			phase_q     <= 1'b0;
			wv_s1       <= 1'b0;
			em_cnt_q    <= '0;
			out_valid_q <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			wv_s1 <= 1'b0;
			if (cmd.store_wr) begin
				if (store_has_room) begin
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.perm_start) begin
				rails_q  <= rails_eff;
				row_q    <= '0;
				pos_q    <= '0;
				k_q      <= '0;
				phase_q  <= 1'b0;
				em_cnt_q <= '0;
			end
			if (cmd.walk) begin
				if (pair) begin
					wv_s1   <= 1'b1;
					k_q     <= k_q + 1'b1;
					pos_q   <= pos_q + POS_W'(step);
					phase_q <= !phase_q;
				end else begin
					row_q   <= row_q + 1'b1;
					pos_q   <= POS_W'(row_q) + 1'b1;
					phase_q <= 1'b0;
				end
			end
			if (cmd.emit_rd) begin
				em_cnt_q    <= em_cnt_q + 1'b1;
				final_q     <= (CNT_W'(em_cnt_q + 1'b1) == count_q);
				out_valid_q <= 1'b1;
			end else if (cmd.out_take) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.run_clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_wr && store_has_room) begin
			store_mem[count_q[AW-1:0]] <= data_byte;
		end
		if (cmd.walk && pair) begin
			st_rd_s1 <= store_mem[walk_rd_addr];
			wa_s1    <= walk_wr_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (wv_s1) begin
			res_mem[wa_s1] <= st_rd_s1;
		end
		if (cmd.emit_rd) begin
			out_q <= res_mem[em_cnt_q[AW-1:0]];
		end
	end

	assign status.walk_done = (k_q == count_q);
	assign status.emit_left = (em_cnt_q < count_q);
	assign status.out_valid = out_valid_q;
	assign status.out_final = final_q;

	assign result_byte   = out_q;
	assign final_result  = final_q;
	assign overflow_flag = ovf_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LEN))
		else $error("byte count beyond buffer depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk && pair) |-> (k_q < count_q))
		else $error("walk produced more positions than bytes");
	assert property (@(posedge clk) disable iff (!arst_n)
		wv_s1 |-> (CNT_W'(wa_s1) < count_q))
		else $error("result write outside message");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_rd |-> (em_cnt_q < count_q))
		else $error("result read past message end");
endmodule

// ===== rtl/rail_fence_cipher_top.sv =====
// channel  role    payload                                          transfer
// msg      sink    data_byte, end_of_message                        valid && ready
// cipher   source  result_byte, final_result, overflow_flag         valid && ready
// cfg      sink    reg_index (0 rail_count, 1 cipher_mode), wr_data valid (ready tied high)
//
// Loading takes one byte per cycle. After the end-marked byte, the rail walker
// copies through the buffer rail by rail, one byte per step on a single-port read,
// then results leave at one per cycle while cipher.ready is high.
// Input is held off (msg.ready low) from the end byte until the last result
// transfers; a stalled cipher.ready holds the current result in its register.
// Reset clears counts, flags and registers to rail_count 3, encrypt.
module rail_fence_cipher_top #(
	parameter int MAX_LEN   = 64,
	parameter int MAX_RAILS = 16
) (
	input logic         clk,
	input logic         arst_n,
	rfc_in_if.sink      msg,
	rfc_out_if.source   cipher,
	rfc_cfg_if.sink     cfg
);
	import rfc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg.ready = 1'b1;

	rfc_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg.valid),
		.msg_eom   (msg.end_of_message),
		.out_ready (cipher.ready),
		.status    (status),
		.msg_ready (msg.ready),
		.cmd       (cmd)
	);

	rfc_dp #(
		.MAX_LEN   (MAX_LEN),
		.MAX_RAILS (MAX_RAILS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.data_byte     (msg.data_byte),
		.cfg_wr        (cfg.valid),
		.cfg_index     (cfg.reg_index),
		.cfg_data      (cfg.wr_data),
		.status        (status),
		.result_byte   (cipher.result_byte),
		.final_result  (cipher.final_result),
		.overflow_flag (cipher.overflow_flag)
	);

	assign cipher.valid = status.out_valid;
endmodule

// ===== test/rfc_cipher_monitor.sv =====
module rfc_cipher_monitor #(
	parameter int MAX_LEN   = 64,
	parameter int MAX_RAILS = 16
) (
	input  logic clk,
	input  logic arst_n,
	rfc_in_if    msg,
	rfc_out_if   cipher,
	rfc_cfg_if   cfg,
	output int   mismatches,
	output int   waiting,
	output int   checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import rfc_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] text;
		logic              last;
		logic              ovf;
	} cipher_out_t;

	cipher_out_t       cipher_due[$];
	logic [DATA_W-1:0] msg_buf [MAX_LEN];
	int                msg_len;
	logic              dropped;
	logic [RAIL_W-1:0] rails_cfg;
	logic              mode_cfg;

	function automatic int rail_at(input int pos, input int rails);
		int span;
		int m;
		if (rails <= 1) return 0;
		span = 2 * (rails - 1);
		m = pos % span;
		return (m < rails) ? m : span - m;
	endfunction

	// Permute the buffered message along the zigzag and queue the cipher bytes.
	function automatic void zigzag_run();
		int                rails;
		int                pos;
		int                row;
		int                k;
		int                walk [MAX_LEN];
		logic [DATA_W-1:0] permuted [MAX_LEN];
		cipher_out_t       word;
		if (rails_cfg == '0) rails = 1;
		else if (rails_cfg > MAX_RAILS) rails = MAX_RAILS;
		else rails = int'(rails_cfg);
		k = 0;
		for (row = 0; row < rails; row++)
			for (pos = 0; pos < msg_len; pos++)
				if (rail_at(pos, rails) == row && k < MAX_LEN) begin
					walk[k] = pos;
					k++;
				end
		for (k = 0; k < msg_len; k++)
			if (mode_cfg == MODE_ENCRYPT) permuted[k] = msg_buf[walk[k]];
			else permuted[walk[k]] = msg_buf[k];
		for (k = 0; k < msg_len; k++) begin
			word.text = permuted[k];
			word.last = (k == msg_len - 1);
			word.ovf  = dropped;
			cipher_due = {cipher_due, word};
		end
		msg_len = 0;
		dropped = 1'b0;
	endfunction

	initial begin
		mismatches = 0;
		waiting    = 0;
		checked    = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		cipher_out_t want;
		if (!arst_n) begin
			cipher_due.delete();
			msg_len   = 0;
			dropped   = 1'b0;
			rails_cfg = RAIL_COUNT_RESET;
			mode_cfg  = MODE_ENCRYPT;
		end else begin
			// retire results before queueing new ones from the same edge
			if (cipher.valid === 1'b1 && cipher.ready === 1'b1) begin
				checked++;
				if (cipher_due.size() == 0) begin
					$error("result_byte %02h transferred with nothing expected",
						cipher.result_byte);
					mismatches++;
				end else begin
					want = cipher_due.pop_front();
					if (cipher.result_byte !== want.text) begin
						$error("result_byte: expected %02h, got %02h", want.text,
							cipher.result_byte);
						mismatches++;
					end
					if (cipher.final_result !== want.last) begin
						$error("final_result: expected %0b, got %0b", want.last,
							cipher.final_result);
						mismatches++;
					end
					if (cipher.overflow_flag !== want.ovf) begin
						$error("overflow_flag: expected %0b, got %0b", want.ovf,
							cipher.overflow_flag);
						mismatches++;
					end
				end
			end
			if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
				if (cfg.reg_index == REG_RAIL_COUNT) rails_cfg = cfg.wr_data;
				else if (cfg.reg_index == REG_CIPHER_MODE) mode_cfg = cfg.wr_data[0];
			end
			if (msg.valid === 1'b1 && msg.ready === 1'b1) begin
				if (msg_len < MAX_LEN) begin
					msg_buf[msg_len] = msg.data_byte;
					msg_len++;
				end else begin
					dropped = 1'b1;
				end
				if (msg.end_of_message) zigzag_run();
			end
		end
		waiting = cipher_due.size();
	end
endmodule

// ===== test/rail_fence_cipher_top_test.sv =====
module rail_fence_cipher_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rfc_pkg::*;

	localparam int MAX_LEN         = 64;
	localparam int MAX_RAILS       = 16;
	localparam int PERIOD          = 12;
	localparam int TARGET_BYTES    = 425;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PRESSURE_MSG    = 10;
	localparam int DRAIN_CYCLES    = 4;
	localparam int TIMEOUT_NS      = 10_000_000;

	localparam logic [DATA_W-1:0] ODD_BYTES [4] = '{8'h00, 8'hFF, 8'h0A, 8'h2A};

	logic clk = 1'b0;
	logic arst_n;

	rfc_in_if  msg();
	rfc_out_if cipher();
	rfc_cfg_if cfg();

	int mismatches;
	int waiting;
	int checked;

	logic              steady = 1'b0;
	logic              hold_off_req = 1'b0;
	logic [DATA_W-1:0] msg_text[$];
	int                bytes_sent = 0;
	int                msgs_sent = 0;
	int                ovf_msgs = 0;
	int                settings_used = 0;

	rail_fence_cipher_top #(
		.MAX_LEN   (MAX_LEN),
		.MAX_RAILS (MAX_RAILS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.cipher (cipher),
		.cfg    (cfg)
	);

	rfc_cipher_monitor #(
		.MAX_LEN   (MAX_LEN),
		.MAX_RAILS (MAX_RAILS)
	) u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.cipher     (cipher),
		.cfg        (cfg),
		.mismatches (mismatches),
		.waiting    (waiting),
		.checked    (checked)
	);

	always #(PERIOD / 2) clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Called at a falling edge; valid stays high unless a gap follows.
	task automatic push_byte(input logic [DATA_W-1:0] d, input logic eom);
		int gap;
		msg.valid          <= 1'b1;
		msg.data_byte      <= d;
		msg.end_of_message <= eom;
		do @(posedge clk); while (msg.ready !== 1'b1);
		@(negedge clk);
		bytes_sent++;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			msg.valid          <= 1'b0;
			msg.data_byte      <= DATA_W'($urandom);
			msg.end_of_message <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_text();
		int i;
		if (msg_text.size() > MAX_LEN) ovf_msgs++;
		for (i = 0; i < msg_text.size(); i++)
			push_byte(msg_text[i], i == msg_text.size() - 1);
		msgs_sent++;
	endtask

	task automatic make_text(input int len);
		msg_text.delete();
		repeat (len) begin
			if ($urandom_range(0, 5) == 0) msg_text = {msg_text, ODD_BYTES[$urandom_range(0, 3)]};
			else msg_text = {msg_text, DATA_W'($urandom)};
		end
	endtask

	// Stop offering and wait until every cipher byte has left the block.
	task automatic drain();
		msg.valid <= 1'b0;
		wait (waiting == 0);
		@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RAIL_W-1:0] val);
		cfg.valid     <= 1'b1;
		cfg.reg_index <= idx;
		cfg.wr_data   <= val;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic set_cfg(input logic [RAIL_W-1:0] rails, input logic mode);
		drain();
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(int'(REG_CIPHER_MODE) + 1,
				(1 << CFG_IDX_W) - 1)), RAIL_W'($urandom));
		write_reg(REG_RAIL_COUNT, rails);
		// upper data bits are don't-care for the mode register
		write_reg(REG_CIPHER_MODE, {(RAIL_W - 1)'($urandom), mode});
		cfg.valid <= 1'b0;
		settings_used++;
	endtask

	task automatic random_setting();
		logic [RAIL_W-1:0] rails;
		case ($urandom_range(0, 5))
			0: begin
				rails = '0;
			end
			1: begin
				rails = RAIL_W'(1);
			end
			2: begin
				rails = RAIL_W'(MAX_RAILS);
			end
			3: begin
				rails = '1;
			end
			default: begin
				rails = RAIL_W'($urandom_range(2, MAX_RAILS + 4));
			end
		endcase
		set_cfg(rails, 1'($urandom));
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		cipher.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = HOLD_OFF_CYCLES;
			end
			if (stall > 0) begin
				stall--;
				cipher.ready <= 1'b0;
			end else if (steady || $urandom_range(0, 3) != 0) begin
				cipher.ready <= 1'b1;
			end else begin
				stall = idle_len();
				cipher.ready <= 1'b0;
			end
		end
	end

	initial begin
		int len;
		msg.valid          = 1'b0;
		msg.data_byte      = '0;
		msg.end_of_message = 1'b0;
		cfg.valid          = 1'b0;
		cfg.reg_index      = REG_RAIL_COUNT;
		cfg.wr_data        = '0;
		arst_n             = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: three rails, encrypt
		steady = 1'b1;
		msg_text = {8'h00, 8'hFF, 8'h0A, 8'h2A, 8'h55, 8'hAA, 8'h01, 8'h80};
		send_text();
		msg_text = {8'h7E};
		send_text();
		steady = 1'b0;
		set_cfg(RAIL_W'(3), MODE_DECRYPT);
		msg_text = {8'h00, 8'hFF, 8'h0A, 8'h2A, 8'h55, 8'hAA, 8'h01, 8'h80};
		send_text();
		set_cfg(RAIL_W'(1), MODE_ENCRYPT);
		msg_text = {8'h0A, 8'h2A, 8'h0A};
		send_text();
		set_cfg('0, MODE_DECRYPT);
		msg_text = {8'h11, 8'h22, 8'h33};
		send_text();
		set_cfg('1, MODE_ENCRYPT);
		msg_text = {8'hC3, 8'h3C};
		send_text();

		while (bytes_sent < TARGET_BYTES) begin
			if (msgs_sent % 4 == 0) random_setting();
			else if (msgs_sent != PRESSURE_MSG + 1 && $urandom_range(0, 7) == 0) drain();
			steady = ($urandom_range(0, 9) == 0);
			if (msgs_sent == 8) begin
				len = MAX_LEN;
			end else if (msgs_sent == 12) begin
				len = MAX_LEN + 6;
			end else if (msgs_sent == PRESSURE_MSG) begin
				// receiver stalls while the next message is already offered
				len = 20;
				steady = 1'b0;
				hold_off_req = 1'b1;
			end else begin
				case ($urandom_range(0, 29))
					0: begin
						len = $urandom_range(MAX_LEN + 1, MAX_LEN + 16);
					end
					1, 2, 3: begin
						len = $urandom_range(17, MAX_LEN);
					end
					default: begin
						len = $urandom_range(1, 16);
					end
				endcase
			end
			make_text(len);
			send_text();
		end
		steady = 1'b0;
		drain();

		$display("Sent %0d messages, %0d bytes (%0d over capacity), over %0d rail/mode settings.",
			msgs_sent, bytes_sent, ovf_msgs, settings_used);
		$display("Checked %0d cipher bytes, %0d mismatches.", checked, mismatches);
		if (mismatches == 0 && waiting == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAIL");
		$finish;
	end
endmodule
